>>> hw/rtl/bse_pkg.sv
package bse_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam logic [7:0] OPC_CONST = 8'd0;
  localparam logic [7:0] OPC_ADD   = 8'd1;
  localparam logic [7:0] OPC_SUB   = 8'd2;
  localparam logic [7:0] OPC_MUL   = 8'd3;
  localparam logic [7:0] OPC_DIV   = 8'd4;
  localparam logic [7:0] OPC_NEG   = 8'd5;
  localparam logic [7:0] OPC_RET   = 8'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic       load;
    logic       rd_second;
    logic       latch_b;
    logic       fpu_start;
    logic       wr_push;
    logic       wr_arith;
    logic       wr_neg;
    logic       ld_ret;
    logic       ld_err;
    logic [1:0] err_code;
  } bse_cmd_t;

  typedef struct packed {
    logic [7:0] op;
    logic       sp_empty;
    logic       sp_lt2;
    logic       sp_full;
    logic       fpu_done;
  } bse_stat_t;

endpackage

>>> hw/rtl/bse_fpu.sv
module bse_fpu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_PRE  = 4'd1;
  localparam logic [3:0] F_MUL  = 4'd2;
  localparam logic [3:0] F_DIV  = 4'd3;
  localparam logic [3:0] F_ADD  = 4'd4;
  localparam logic [3:0] F_NORM = 4'd5;
  localparam logic [3:0] F_DEN  = 4'd6;
  localparam logic [3:0] F_RND  = 4'd7;
  localparam logic [3:0] F_DONE = 4'd8;

  logic [3:0] fst;
  logic [7:0] op_r;
  logic sa, sb, sr;
  logic [52:0] ma, mb;
  logic signed [13:0] ea, eb, ee;
  logic [105:0] acc;
  logic [54:0] rem;
  logic [55:0] q;
  logic [5:0] cnt;
  logic [107:0] mm;

  // Operand unpacking and special cases.
  logic a_sub, b_sub, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic sb_in, sx, spec;
  logic [63:0] spec_res;

  always_comb begin
    a_sub  = a[62:52] == 11'd0;
    b_sub  = b[62:52] == 11'd0;
    a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    a_zero = a[62:0] == 63'd0;
    b_zero = b[62:0] == 63'd0;
    sb_in  = b[63] ^ (op == bse_pkg::OPC_SUB);
    sx     = a[63] ^ b[63];
    spec     = 1'b1;
    spec_res = bse_pkg::QNAN_BITS;
    if (a_nan || b_nan) begin
      spec_res = bse_pkg::QNAN_BITS;
    end else begin
      case (op)
        bse_pkg::OPC_ADD, bse_pkg::OPC_SUB: begin
          if (a_inf && b_inf) begin
            spec_res = (a[63] == sb_in) ? {a[63], 11'h7FF, 52'd0} : bse_pkg::QNAN_BITS;
          end else if (a_inf) begin
            spec_res = {a[63], 11'h7FF, 52'd0};
          end else if (b_inf) begin
            spec_res = {sb_in, 11'h7FF, 52'd0};
          end else if (a_zero && b_zero) begin
            spec_res = {a[63] & sb_in, 63'd0};
          end else if (a_zero) begin
            spec_res = {sb_in, b[62:0]};
          end else if (b_zero) begin
            spec_res = a;
          end else begin
            spec = 1'b0;
          end
        end
        bse_pkg::OPC_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_res = bse_pkg::QNAN_BITS;
          end else if (a_inf || b_inf) begin
            spec_res = {sx, 11'h7FF, 52'd0};
          end else if (a_zero || b_zero) begin
            spec_res = {sx, 63'd0};
          end else begin
            spec = 1'b0;
          end
        end
        default: begin
          if (b_zero) begin
            spec_res = a_zero ? bse_pkg::QNAN_BITS : {sx, 11'h7FF, 52'd0};
          end else if (a_inf && b_inf) begin
            spec_res = bse_pkg::QNAN_BITS;
          end else if (a_inf) begin
            spec_res = {sx, 11'h7FF, 52'd0};
          end else if (b_inf || a_zero) begin
            spec_res = {sx, 63'd0};
          end else begin
            spec = 1'b0;
          end
        end
      endcase
    end
  end

  // Multiply, divide and align-add steps.
  logic [105:0] acc_nxt;
  logic div_ge;
  logic [54:0] div_diff;
  logic [55:0] q_nxt;
  logic a_ge, add_sign;
  logic signed [13:0] emax;
  logic [13:0] dexp;
  logic [52:0] mx, mn;
  logic [107:0] big, sm_full, sm, sum;
  logic lost;

  always_comb begin
    acc_nxt  = {acc[104:0], 1'b0} + (mb[52] ? {53'd0, ma} : 106'd0);
    div_ge   = rem >= {2'b00, mb};
    div_diff = div_ge ? rem - {2'b00, mb} : rem;
    q_nxt    = {q[54:0], div_ge};
    a_ge     = (ea > eb) || ((ea == eb) && (ma >= mb));
    emax     = a_ge ? ea : eb;
    dexp     = a_ge ? 14'(ea - eb) : 14'(eb - ea);
    mx       = a_ge ? ma : mb;
    mn       = a_ge ? mb : ma;
    add_sign = a_ge ? sa : sb;
    big      = {1'b0, mx, 54'd0};
    sm_full  = {1'b0, mn, 54'd0};
    if (dexp >= 14'd108) begin
      sm   = 108'd1;
      lost = 1'b0;
    end else begin
      lost = |(sm_full & ~({108{1'b1}} << dexp[6:0]));
      sm   = (sm_full >> dexp[6:0]) | {107'd0, lost};
    end
    sum = (sa == sb) ? big + sm : big - sm;
  end

  // Round to nearest even and pack.
  logic [53:0] mant, mr;
  logic rnd_inc;
  logic signed [13:0] rexp;
  logic [51:0] rfrac;
  logic [63:0] rnd_res;

  always_comb begin
    mant    = {1'b0, mm[107:55]};
    rnd_inc = mm[54] & ((|mm[53:0]) | mm[55]);
    mr      = mant + {53'd0, rnd_inc};
    if (mr[53]) begin
      rexp  = ee + 14'sd1;
      rfrac = 52'd0;
    end else begin
      rexp  = mr[52] ? ee : 14'sd0;
      rfrac = mr[51:0];
    end
    if (rexp >= 14'sd2047) begin
      rnd_res = {sr, 11'h7FF, 52'd0};
    end else begin
      rnd_res = {sr, rexp[10:0], rfrac};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fst <= F_IDLE;
    end else begin
      case (fst)
        F_IDLE: begin
          if (start) begin
            op_r <= op;
            sa   <= a[63];
            sb   <= sb_in;
            sr   <= sx;
            ma   <= {~a_sub, a[51:0]};
            mb   <= {~b_sub, b[51:0]};
            ea   <= a_sub ? 14'sd1 : $signed({3'b000, a[62:52]});
            eb   <= b_sub ? 14'sd1 : $signed({3'b000, b[62:52]});
            res  <= spec_res;
            fst  <= spec ? F_DONE : F_PRE;
          end
        end
        F_PRE: begin
          if (!ma[52]) begin
            ma <= {ma[51:0], 1'b0};
            ea <= ea - 14'sd1;
          end
          if (!mb[52]) begin
            mb <= {mb[51:0], 1'b0};
            eb <= eb - 14'sd1;
          end
          if (ma[52] && mb[52]) begin
            case (op_r)
              bse_pkg::OPC_MUL: begin
                acc <= 106'd0;
                cnt <= 6'd52;
                fst <= F_MUL;
              end
              bse_pkg::OPC_DIV: begin
                rem <= {2'b00, ma};
                q   <= 56'd0;
                cnt <= 6'd55;
                fst <= F_DIV;
              end
              default: fst <= F_ADD;
            endcase
          end
        end
        F_MUL: begin
          acc <= acc_nxt;
          mb  <= {mb[51:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            mm  <= {acc_nxt, 2'b00};
            ee  <= ea + eb - 14'sd1022;
            fst <= F_NORM;
          end
        end
        F_DIV: begin
          q   <= q_nxt;
          rem <= {div_diff[53:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            mm  <= {q_nxt, 52'd0} | {107'd0, div_diff != 55'd0};
            ee  <= ea - eb + 14'sd1023;
            fst <= F_NORM;
          end
        end
        F_ADD: begin
          sr <= add_sign;
          mm <= sum;
          ee <= emax + 14'sd1;
          if (sum == 108'd0) begin
            // Exact cancellation rounds to positive zero.
            res <= 64'd0;
            fst <= F_DONE;
          end else begin
            fst <= F_NORM;
          end
        end
        F_NORM: begin
          if (mm[107]) begin
            fst <= F_DEN;
          end else begin
            mm <= {mm[106:0], 1'b0};
            ee <= ee - 14'sd1;
          end
        end
        F_DEN: begin
          if (ee >= 14'sd1) begin
            fst <= F_RND;
          end else if (ee < -14'sd120) begin
            // Everything lands below the round bit; only the sticky survives.
            mm <= {107'd0, |mm};
            ee <= 14'sd1;
          end else begin
            mm <= {1'b0, mm[107:2], mm[1] | mm[0]};
            ee <= ee + 14'sd1;
          end
        end
        F_RND: begin
          res <= rnd_res;
          fst <= F_DONE;
        end
        F_DONE: fst <= F_IDLE;
        default: fst <= F_IDLE;
      endcase
    end
  end

  assign done = fst == F_DONE;

endmodule

>>> hw/rtl/bse_dpath.sv
module bse_dpath (
  input  logic              clk,
  input  logic              rst,
  input  bse_pkg::bse_cmd_t cmd,
  output bse_pkg::bse_stat_t stat,
  input  logic [7:0]        func,
  input  logic [63:0]       constant_value,
  output logic [63:0]       result_value,
  output logic [1:0]        status
);

  logic [7:0] op_q;
  logic [63:0] cval;
  logic [bse_pkg::SP_W-1:0] sp;
  logic [63:0] b_q;
  logic [63:0] rdata;
  logic [63:0] mem [bse_pkg::STACK_DEPTH];
  logic [bse_pkg::ADDR_W-1:0] addr_top, addr_second, addr_push, rd_addr, wr_addr;
  logic wr_en;
  logic [63:0] wr_data;
  logic fpu_done;
  logic [63:0] fpu_res;

  assign addr_top    = bse_pkg::ADDR_W'(sp - bse_pkg::SP_W'(1));
  assign addr_second = bse_pkg::ADDR_W'(sp - bse_pkg::SP_W'(2));
  assign addr_push   = bse_pkg::ADDR_W'(sp);
  assign rd_addr     = cmd.rd_second ? addr_second : addr_top;

  always_comb begin
    wr_en   = cmd.wr_push | cmd.wr_arith | cmd.wr_neg;
    wr_addr = addr_top;
    wr_data = rdata ^ bse_pkg::SIGN_BIT;
    if (cmd.wr_push) begin
      wr_addr = addr_push;
      wr_data = cval;
    end else if (cmd.wr_arith) begin
      wr_addr = addr_second;
      wr_data = fpu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.wr_push) begin
      sp <= sp + bse_pkg::SP_W'(1);
    end else if (cmd.wr_arith || cmd.ld_ret) begin
      sp <= sp - bse_pkg::SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= func;
      cval <= constant_value;
    end
    if (cmd.latch_b) begin
      b_q <= rdata;
    end
    if (cmd.ld_ret) begin
      result_value <= rdata;
      status       <= bse_pkg::ST_OK;
    end else if (cmd.ld_err) begin
      result_value <= 64'd0;
      status       <= cmd.err_code;
    end
  end

  bse_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fpu_start),
    .op    (op_q),
    .a     (rdata),
    .b     (b_q),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  assign stat.op       = op_q;
  assign stat.sp_empty = sp == '0;
  assign stat.sp_lt2   = sp < bse_pkg::SP_W'(2);
  assign stat.sp_full  = sp == bse_pkg::SP_W'(bse_pkg::STACK_DEPTH);
  assign stat.fpu_done = fpu_done;

endmodule

>>> hw/rtl/bse_ctrl.sv
module bse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bse_pkg::bse_stat_t stat,
  output bse_pkg::bse_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_RDA  = 3'd3;
  localparam logic [2:0] S_FPU  = 3'd4;
  localparam logic [2:0] S_RDT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        // The top entry is read here for every opcode that needs it.
        case (stat.op)
          bse_pkg::OPC_CONST: begin
            if (stat.sp_full) begin
              cmd.ld_err   = 1'b1;
              cmd.err_code = bse_pkg::ST_OVER;
              state_next   = S_OUT;
            end else begin
              cmd.wr_push = 1'b1;
              state_next  = S_IDLE;
            end
          end
          bse_pkg::OPC_ADD, bse_pkg::OPC_SUB, bse_pkg::OPC_MUL, bse_pkg::OPC_DIV: begin
            if (stat.sp_lt2) begin
              cmd.ld_err   = 1'b1;
              cmd.err_code = bse_pkg::ST_UNDER;
              state_next   = S_OUT;
            end else begin
              state_next = S_RDB;
            end
          end
          bse_pkg::OPC_NEG, bse_pkg::OPC_RET: begin
            if (stat.sp_empty) begin
              cmd.ld_err   = 1'b1;
              cmd.err_code = bse_pkg::ST_UNDER;
              state_next   = S_OUT;
            end else begin
              state_next = S_RDT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RDB: begin
        cmd.latch_b   = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_RDA;
      end
      S_RDA: begin
        cmd.fpu_start = 1'b1;
        state_next    = S_FPU;
      end
      S_FPU: begin
        if (stat.fpu_done) begin
          cmd.wr_arith = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RDT: begin
        if (stat.op == bse_pkg::OPC_NEG) begin
          cmd.wr_neg = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.ld_ret = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

endmodule

>>> hw/rtl/bytecode_stack_evaluator_core.sv
// Stack-machine evaluator on IEEE double operands, one instruction per input transfer. Items
// are handled one at a time. A stack error or a return offers a result, which then waits
// for its output transfer. Multiply and divide run the bit-serial multiply and restoring
// divide loops in the float unit, and add and subtract take longer with each bit of
// cancellation. Special operands (zero, infinity, NaN) finish the float unit in one step.
// Subnormal operands add one-bit normalization steps, and results in the subnormal range add
// one-bit denormalization steps. Stack entries sit in a memory with a single read port, so
// the two operands of an arithmetic instruction are read in successive cycles.
module bytecode_stack_evaluator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  func,
  input  logic [63:0] constant_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_value,
  output logic [1:0]  status
);

  bse_pkg::bse_cmd_t  cmd;
  bse_pkg::bse_stat_t stat;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bse_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .constant_value (constant_value),
    .result_value   (result_value),
    .status         (status)
  );

  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an input transfer");

  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated after an output transfer");

endmodule
